[design/rrts_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the round-robin task scheduler
package rrts_pkg;

    // default size and reset values
    localparam int NUM_TASKS_DEF = 16;
    localparam logic [7:0] QUANTUM_AT_RESET = 8'd7;

    // field widths of the channels
    localparam int OPCODE_W = 2;
    localparam int SLEEP_W  = 8;
    localparam int TIDX_W   = 4;
    localparam int QLEN_W   = 8;
    localparam int LIVE_W   = 5;
    localparam int WAIT_W   = 32;

    // event codes
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_IO   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EXIT = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

    // task status codes
    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_SLEEP   = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    // commands broadcast from the sequencer to every cell
    typedef struct packed {
        logic               do_tick;
        logic               do_io;
        logic               do_refill;
        logic               tok_load;
        logic               pick_en;
        logic [SLEEP_W-1:0] sleep_ticks;
        logic [QLEN_W-1:0]  quantum_len;
    } t_cell_cmd;

    // status reported by each cell
    typedef struct packed {
        logic ready;
        logic running;
        logic live;
        logic has_quantum;
        logic expire;
        logic done;
        logic claim;
    } t_cell_stat;

endpackage

[design/rrts_in_if.sv]
`timescale 1ns / 1ps
// event channel of the scheduler
interface rrts_in_if;
    logic                         valid;
    logic                         ready;
    logic [rrts_pkg::OPCODE_W-1:0] opcode;
    logic [rrts_pkg::SLEEP_W-1:0]  sleep_ticks;
    logic [rrts_pkg::TIDX_W-1:0]   task_index;

    modport source (output valid, output opcode, output sleep_ticks, output task_index,
                    input ready);
    modport sink (input valid, input opcode, input sleep_ticks, input task_index,
                  output ready);
endinterface

[design/rrts_out_if.sv]
`timescale 1ns / 1ps
// result channel of the scheduler
interface rrts_out_if;
    logic                        valid;
    logic                        ready;
    logic                        running_valid;
    logic [rrts_pkg::TIDX_W-1:0] running_task;
    logic                        step_valid;
    logic [rrts_pkg::TIDX_W-1:0] step_task;
    logic                        quantum_expired;
    logic                        quantum_refilled;
    logic [rrts_pkg::LIVE_W-1:0] live_tasks;
    logic [rrts_pkg::WAIT_W-1:0] wait_count;
    logic                        event_ignored;

    modport source (output valid, output running_valid, output running_task,
                    output step_valid, output step_task, output quantum_expired,
                    output quantum_refilled, output live_tasks, output wait_count,
                    output event_ignored, input ready);
    modport sink (input valid, input running_valid, input running_task,
                  input step_valid, input step_task, input quantum_expired,
                  input quantum_refilled, input live_tasks, input wait_count,
                  input event_ignored, output ready);
endinterface

[design/rrts_cell.sv]
`timescale 1ns / 1ps
// one task slot of the scheduler ring: status, quantum, io wait and search token
module rrts_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrts_pkg::t_cell_cmd  i_cmd,
    input  logic                 i_exit,
    input  logic                 i_tok_start,
    input  logic                 i_token,
    output logic                 o_token,
    output rrts_pkg::t_cell_stat o_stat
);

    rrts_pkg::t_status                r_status;
    logic [rrts_pkg::QLEN_W-1:0]      r_quantum;
    logic [rrts_pkg::SLEEP_W-1:0]     r_sleep;
    logic                             r_token;
    logic                             claim;

    // this slot takes the cpu when the search token sits here and it can run
    assign claim = i_cmd.pick_en && r_token && (r_status == rrts_pkg::ST_READY)
                   && (r_quantum != '0);

    // status toward the sequencer
    always_comb begin
        o_stat.ready       = (r_status == rrts_pkg::ST_READY);
        o_stat.running     = (r_status == rrts_pkg::ST_RUNNING);
        o_stat.live        = (r_status != rrts_pkg::ST_DONE);
        o_stat.has_quantum = (r_status != rrts_pkg::ST_DONE) && (r_quantum != '0);
        o_stat.expire      = (r_status == rrts_pkg::ST_RUNNING) && (r_quantum <= 8'd1);
        o_stat.done        = (r_status == rrts_pkg::ST_DONE);
        o_stat.claim       = claim;
    end

    assign o_token = r_token;

    // slot state and token hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= rrts_pkg::ST_READY;
            r_quantum <= rrts_pkg::QUANTUM_AT_RESET;
            r_sleep   <= '0;
            r_token   <= 1'b0;
        end else begin
            r_token <= i_cmd.tok_load ? i_tok_start : i_token;

            // timer tick: io countdown and quantum use
            if (i_cmd.do_tick) begin
                case (r_status)
                    rrts_pkg::ST_SLEEP: begin
                        if (r_sleep <= 8'd1) begin
                            r_sleep  <= '0;
                            r_status <= rrts_pkg::ST_READY;
                        end else begin
                            r_sleep <= r_sleep - 8'd1;
                        end
                    end
                    rrts_pkg::ST_RUNNING: begin
                        if (r_quantum <= 8'd1) begin
                            r_quantum <= '0;
                            r_status  <= rrts_pkg::ST_READY;
                        end else begin
                            r_quantum <= r_quantum - 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // running task blocks on io
            if (i_cmd.do_io && (r_status == rrts_pkg::ST_RUNNING)) begin
                r_status <= rrts_pkg::ST_SLEEP;
                r_sleep  <= i_cmd.sleep_ticks;
            end

            if (i_exit) begin
                r_status <= rrts_pkg::ST_DONE;
            end

            if (claim) begin
                r_status <= rrts_pkg::ST_RUNNING;
            end

            if (i_cmd.do_refill && (r_status != rrts_pkg::ST_DONE)) begin
                r_quantum <= i_cmd.quantum_len;
            end
        end
    end

endmodule

[design/round_robin_task_scheduler.sv]
`timescale 1ns / 1ps
// top level: event sequencer around a ring of task slot cells
//
// Round-robin task scheduler with a time quantum, NUM_TASKS task slots.
// Events come in on i_evt (valid/ready): timer tick, io request by the
// running task, or exit of task task_index. One result item per event goes
// out on o_res (valid/ready) and reports the running task, the run step
// granted by a tick, quantum expiry and refill, live task count, the
// saturating total wait and whether the event was ignored.
// The quantum length register is written through i_cfg_we / i_cfg_data.
// The user must write it only while no event is in flight; the block itself
// does not enforce this. Timing: an event is taken in the idle state,
// applied to all cells in the next cycle, then a search token walks the
// cell ring one slot per cycle when a new task must be picked, followed by
// a refill check state and a state that loads the result register. The
// next event is taken only after the result register is loaded.
// A stalled receiver holds the result register; the block then waits in
// its last step before it takes another event. Synchronous reset puts all
// tasks ready with quantum 7, nothing running and the quantum length at 7.
module round_robin_task_scheduler #(
    parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rrts_in_if.sink                     i_evt,
    rrts_out_if.source                  o_res,
    input  logic                        i_cfg_we,
    input  logic [rrts_pkg::QLEN_W-1:0] i_cfg_data
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PICK,
        S_CHECK,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [rrts_pkg::OPCODE_W-1:0]   r_op;
    logic [rrts_pkg::SLEEP_W-1:0]    r_sleep_ticks;
    logic [rrts_pkg::TIDX_W-1:0]     r_tidx;
    logic [LW-1:0]                   r_ready_cnt;
    logic                            r_cur_valid;
    logic [TW-1:0]                   r_cur;
    logic [LW-1:0]                   r_live;
    logic [rrts_pkg::WAIT_W-1:0]     r_wait;
    logic [rrts_pkg::QLEN_W-1:0]     r_qlen;
    logic [TW-1:0]                   r_pos;
    logic [TW-1:0]                   r_cnt;
    logic                            r_chk;
    logic                            r_step_valid;
    logic [TW-1:0]                   r_step_task;
    logic                            r_expired;
    logic                            r_refilled;
    logic                            r_ignored;

    // result register
    logic                            r_o_valid;
    logic                            r_o_running_valid;
    logic [rrts_pkg::TIDX_W-1:0]     r_o_running_task;
    logic                            r_o_step_valid;
    logic [rrts_pkg::TIDX_W-1:0]     r_o_step_task;
    logic                            r_o_expired;
    logic                            r_o_refilled;
    logic [rrts_pkg::LIVE_W-1:0]     r_o_live;
    logic [rrts_pkg::WAIT_W-1:0]     r_o_wait;
    logic                            r_o_ignored;

    rrts_pkg::t_cell_cmd             cell_cmd;
    rrts_pkg::t_cell_stat            cell_stat [NUM_TASKS];
    logic [NUM_TASKS-1:0]            tok_out;
    logic [NUM_TASKS-1:0]            tok_start;
    logic [NUM_TASKS-1:0]            exit_sel;
    logic [NUM_TASKS-1:0]            ready_vec;
    logic [NUM_TASKS-1:0]            running_vec;
    logic [NUM_TASKS-1:0]            live_vec;
    logic [NUM_TASKS-1:0]            quant_vec;
    logic [NUM_TASKS-1:0]            expire_vec;
    logic [NUM_TASKS-1:0]            done_vec;
    logic [NUM_TASKS-1:0]            claim_vec;
    logic [NUM_TASKS-1:0]            tidx_vec;
    logic [LW-1:0]                   ready_pop;

    logic                            c_tick;
    logic                            c_io;
    logic                            c_exit;
    logic                            live_nz;
    logic                            exit_ok;
    logic                            cur_hit;
    logic                            ignore;
    logic                            go_pick;
    logic                            from_cur;
    logic [TW-1:0]                   cur_next;
    logic [TW-1:0]                   start_pos;
    logic [TW-1:0]                   pos_next;
    logic [LW-1:0]                   live_after;
    logic                            found;
    logic                            do_refill;
    logic [rrts_pkg::WAIT_W:0]       wait_sum;
    logic [rrts_pkg::WAIT_W-1:0]     n_wait;
    logic [31:0]                     cur_ext;
    logic [31:0]                     step_ext;
    logic [31:0]                     live_ext;

    // gather cell status into vectors and count ready tasks
    always_comb begin
        ready_pop = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            ready_vec[i]   = cell_stat[i].ready;
            running_vec[i] = cell_stat[i].running;
            live_vec[i]    = cell_stat[i].live;
            quant_vec[i]   = cell_stat[i].has_quantum;
            expire_vec[i]  = cell_stat[i].expire;
            done_vec[i]    = cell_stat[i].done;
            claim_vec[i]   = cell_stat[i].claim;
            tidx_vec[i]    = (32'(r_tidx) == 32'(i));
            ready_pop      = ready_pop + LW'(ready_vec[i]);
        end
    end

    // event decode on the latched item, against the state before the update
    always_comb begin
        c_tick     = (r_op == rrts_pkg::OP_TICK);
        c_io       = (r_op == rrts_pkg::OP_IO);
        c_exit     = (r_op == rrts_pkg::OP_EXIT);
        live_nz    = (r_live != '0);
        exit_ok    = c_exit && (32'(r_tidx) < NUM_TASKS) && !(|(tidx_vec & done_vec));
        cur_hit    = r_cur_valid && (32'(r_cur) == 32'(r_tidx));
        live_after = (exit_ok && live_nz) ? (r_live - LW'(1)) : r_live;
        ignore     = (c_tick && !live_nz) || (c_io && !r_cur_valid)
                     || (c_exit && !exit_ok) || (r_op == rrts_pkg::OP_NONE);
        go_pick    = (c_tick && live_nz && (r_cur_valid ? (|expire_vec) : 1'b1))
                     || (c_io && r_cur_valid)
                     || (exit_ok && cur_hit && (live_after != '0));
        from_cur   = (c_tick && r_cur_valid) || c_io;
        cur_next   = (32'(r_cur) == NUM_TASKS - 1) ? '0 : (r_cur + TW'(1));
        start_pos  = from_cur ? cur_next : '0;
        pos_next   = (32'(r_pos) == NUM_TASKS - 1) ? '0 : (r_pos + TW'(1));
        found      = |claim_vec;
        do_refill  = (r_state == S_CHECK) && r_chk && (r_live != '0) && !(|quant_vec);
        wait_sum   = {1'b0, r_wait} + (rrts_pkg::WAIT_W + 1)'(r_ready_cnt);
        n_wait     = wait_sum[rrts_pkg::WAIT_W] ? '1 : wait_sum[rrts_pkg::WAIT_W-1:0];
        for (int i = 0; i < NUM_TASKS; i++) begin
            tok_start[i] = (32'(start_pos) == 32'(i));
            exit_sel[i]  = (r_state == S_EXEC) && exit_ok && tidx_vec[i];
        end
    end

    // commands to the cell ring
    always_comb begin
        cell_cmd.do_tick     = (r_state == S_EXEC) && c_tick && live_nz;
        cell_cmd.do_io       = (r_state == S_EXEC) && c_io && r_cur_valid;
        cell_cmd.do_refill   = do_refill;
        cell_cmd.tok_load    = (r_state == S_EXEC);
        cell_cmd.pick_en     = (r_state == S_PICK);
        cell_cmd.sleep_ticks = r_sleep_ticks;
        cell_cmd.quantum_len = r_qlen;
    end

    // ring of task cells, token passed to the next higher slot
    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
        localparam int PREV = (g == 0) ? NUM_TASKS - 1 : g - 1;
        rrts_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cell_cmd),
            .i_exit      (exit_sel[g]),
            .i_tok_start (tok_start[g]),
            .i_token     (tok_out[PREV]),
            .o_token     (tok_out[g]),
            .o_stat      (cell_stat[g])
        );
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_live      <= LW'(NUM_TASKS);
            r_wait      <= '0;
            r_qlen      <= rrts_pkg::QUANTUM_AT_RESET;
            r_o_valid   <= 1'b0;
            r_chk       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_qlen <= i_cfg_data;
            end

            // the last step reloads the result register itself
            if (r_o_valid && o_res.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_evt.valid) begin
                        r_op          <= i_evt.opcode;
                        r_sleep_ticks <= i_evt.sleep_ticks;
                        r_tidx        <= i_evt.task_index;
                        r_ready_cnt   <= ready_pop;
                        r_step_valid  <= 1'b0;
                        r_step_task   <= '0;
                        r_expired     <= 1'b0;
                        r_refilled    <= 1'b0;
                        r_state       <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (c_tick && live_nz) begin
                        r_wait       <= n_wait;
                        r_step_valid <= r_cur_valid;
                        r_step_task  <= r_cur;
                        r_expired    <= r_cur_valid && (|expire_vec);
                    end
                    if (exit_ok) begin
                        r_live <= live_after;
                        if (cur_hit) begin
                            r_cur_valid <= 1'b0;
                            r_cur       <= '0;
                        end
                    end
                    r_ignored <= ignore;
                    r_chk     <= c_tick && live_nz;
                    r_pos     <= start_pos;
                    r_cnt     <= '0;
                    r_state   <= go_pick ? S_PICK : S_CHECK;
                end
                S_PICK: begin
                    if (found) begin
                        r_cur_valid <= 1'b1;
                        r_cur       <= r_pos;
                        r_state     <= S_CHECK;
                    end else if (32'(r_cnt) == NUM_TASKS - 1) begin
                        // full lap without a runnable task
                        r_cur_valid <= 1'b0;
                        r_cur       <= '0;
                        r_chk       <= 1'b1;
                        r_state     <= S_CHECK;
                    end else begin
                        r_pos <= pos_next;
                        r_cnt <= r_cnt + TW'(1);
                    end
                end
                S_CHECK: begin
                    if (do_refill) begin
                        r_refilled <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || o_res.ready) begin
                        r_o_valid         <= 1'b1;
                        r_o_running_valid <= r_cur_valid;
                        r_o_running_task  <= cur_ext[rrts_pkg::TIDX_W-1:0];
                        r_o_step_valid    <= r_step_valid;
                        r_o_step_task     <= step_ext[rrts_pkg::TIDX_W-1:0];
                        r_o_expired       <= r_expired;
                        r_o_refilled      <= r_refilled;
                        r_o_live          <= live_ext[rrts_pkg::LIVE_W-1:0];
                        r_o_wait          <= r_wait;
                        r_o_ignored       <= r_ignored;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // width adjust of the reported indexes and count
    assign cur_ext  = 32'(r_cur);
    assign step_ext = 32'(r_step_task);
    assign live_ext = 32'(r_live);

    // channel outputs
    assign i_evt.ready            = (r_state == S_IDLE);
    assign o_res.valid            = r_o_valid;
    assign o_res.running_valid    = r_o_running_valid;
    assign o_res.running_task     = r_o_running_task;
    assign o_res.step_valid       = r_o_step_valid;
    assign o_res.step_task        = r_o_step_task;
    assign o_res.quantum_expired  = r_o_expired;
    assign o_res.quantum_refilled = r_o_refilled;
    assign o_res.live_tasks       = r_o_live;
    assign o_res.wait_count       = r_o_wait;
    assign o_res.event_ignored    = r_o_ignored;

`ifndef NO_ASSERTIONS
    // never more than one task on the cpu
    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(running_vec))
        else $error("more than one task running");

    // between events the current task pointer agrees with the cell ring
    a_cur_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cur_valid == (|running_vec)))
        else $error("current task flag disagrees with cell status");

    // between events the live count agrees with the cells not yet done
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_live) == $countones(live_vec)))
        else $error("live count disagrees with cell status");

    // a result without a running task reports task zero
    a_idle_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_running_valid) |-> (r_o_running_task == '0))
        else $error("running task nonzero with no task running");
`endif

endmodule
